// File: design/iqam_pkg.sv
// Shared types and constants of the IPv4 query AS matcher.
package iqam_pkg;

	localparam int NUM_QUERIES_DEF = 16;
	localparam int SLOT_W = 4;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam int ASN_W = 32;
	localparam int STATUS_W = 2;
	localparam int CMD_W = 2;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(32);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ROUTE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ABSENT  = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_KNOWN   = 2'd2
	} status_t;

	// Transaction as it travels along the row of cells. For a route, data holds
	// the prefix and mask the length mask; for a load, data holds the address;
	// for a read, data, asn and status collect the contents of the slot.
	typedef struct packed {
		logic                valid;
		cmd_t                cmd;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   data;
		logic [ADDR_W-1:0]   mask;
		logic [ASN_W-1:0]    asn;
		status_t             status;
	} tok_t;

endpackage

// File: design/iqam_req_if.sv
// Request channel: commands with load, route and read payload.
interface iqam_req_if;
	import iqam_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SLOT_W-1:0]   slot;
	logic [ADDR_W-1:0]   query_addr;
	logic [ADDR_W-1:0]   route_prefix;
	logic [LEN_W-1:0]    route_len;
	logic [ASN_W-1:0]    route_asn;

	modport source (output valid, cmd, slot, query_addr, route_prefix, route_len, route_asn,
		input ready);
	modport sink (input valid, cmd, slot, query_addr, route_prefix, route_len, route_asn,
		output ready);
endinterface

// File: design/iqam_rsp_if.sv
// Response channel: contents of one slot returned by a read.
interface iqam_rsp_if;
	import iqam_pkg::*;
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   out_slot;
	logic [ADDR_W-1:0]   out_addr;
	logic [STATUS_W-1:0] out_status;
	logic [ASN_W-1:0]    out_asn;

	modport source (output valid, out_slot, out_addr, out_status, out_asn, input ready);
	modport sink (input valid, out_slot, out_addr, out_status, out_asn, output ready);
endinterface

// File: design/iqam_head.sv
// Entry stage: drops repeated routes, builds the length mask, forms the transaction.
module iqam_head
	import iqam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                req_valid,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [ADDR_W-1:0]   query_addr,
	input  logic [ADDR_W-1:0]   route_prefix,
	input  logic [LEN_W-1:0]    route_len,
	input  logic [ASN_W-1:0]    route_asn,
	output tok_t                tok
);

	logic [ADDR_W-1:0] prev_prefix_q;
	logic [LEN_W-1:0]  prev_len_q;
	logic              prev_valid_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              is_route;
	logic              dup;
	logic [LEN_W-1:0]  sat_len;

	assign is_route = (cmd == CMD_ROUTE);
	assign dup = prev_valid_q && (prev_prefix_q == route_prefix) && (prev_len_q == route_len);
	assign sat_len = (route_len > LEN_MAX) ? LEN_MAX : route_len;

	always_comb begin
		tok_d        = '0;
		tok_d.cmd    = cmd_t'(cmd);
		tok_d.slot   = slot;
		tok_d.status = ST_ABSENT;
		unique case (cmd)
			CMD_LOAD: begin
				tok_d.valid = req_valid;
				tok_d.data  = query_addr;
			end
			CMD_ROUTE: begin
				tok_d.valid = req_valid && !dup;
				tok_d.data  = route_prefix;
				tok_d.mask  = ~({ADDR_W{1'b1}} >> sat_len);
				tok_d.asn   = route_asn;
			end
			CMD_READ: begin
				tok_d.valid = req_valid;
			end
			default: begin
				tok_d.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_prefix_q <= '0;
			prev_len_q    <= '0;
			prev_valid_q  <= 1'b0;
			tok_q         <= '0;
		end else if (en) begin
			tok_q <= tok_d;
			if (req_valid && is_route && !dup) begin
				prev_prefix_q <= route_prefix;
				prev_len_q    <= route_len;
				prev_valid_q  <= 1'b1;
			end
		end
	end

	assign tok = tok_q;

endmodule

// File: design/iqam_cell.sv
// One query slot: holds address, status and AS, acts on each passing transaction.
module iqam_cell
	import iqam_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  tok_t tok_in,
	output tok_t tok_out
);

	localparam bit REACHABLE = IDX < (1 << SLOT_W);

	logic [ADDR_W-1:0] addr_q;
	status_t           status_q;
	logic [ASN_W-1:0]  asn_q;
	tok_t              tok_q;

	logic [ADDR_W-1:0] addr_d;
	status_t           status_d;
	logic [ASN_W-1:0]  asn_d;
	tok_t              tok_d;
	logic              sel;
	logic              octet_eq;
	logic              covered;

	assign sel = REACHABLE && (tok_in.slot == SLOT_W'(IDX));
	assign octet_eq = (addr_q[ADDR_W-1 -: 8] == tok_in.data[ADDR_W-1 -: 8]);
	assign covered = (((addr_q ^ tok_in.data) & tok_in.mask) == '0);

	always_comb begin
		addr_d   = addr_q;
		status_d = status_q;
		asn_d    = asn_q;
		tok_d    = tok_in;
		if (tok_in.valid) begin
			unique case (tok_in.cmd)
				CMD_LOAD: begin
					if (sel) begin
						addr_d   = tok_in.data;
						status_d = ST_ABSENT;
						asn_d    = '0;
					end
				end
				CMD_ROUTE: begin
					if (octet_eq) begin
						if (covered) begin
							status_d = ST_KNOWN;
							asn_d    = tok_in.asn;
						end else if (status_q == ST_ABSENT) begin
							status_d = ST_UNKNOWN;
						end
					end
				end
				CMD_READ: begin
					if (sel) begin
						tok_d.data   = addr_q;
						tok_d.status = status_q;
						tok_d.asn    = (status_q == ST_KNOWN) ? asn_q : '0;
					end
				end
				default: begin
					tok_d.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			status_q <= ST_ABSENT;
			asn_q    <= '0;
			tok_q    <= '0;
		end else if (en) begin
			addr_q   <= addr_d;
			status_q <= status_d;
			asn_q    <= asn_d;
			tok_q    <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: design/ipv4_query_asn_matcher.sv
// A read passes the entry register, each slot cell register and then the output register.
// Throughput: one transaction per cycle; each one walks the row of slot cells, one cell a cycle.
// The whole row advances together; it holds only while a response waits on the output register.
// Reset (arst_n low) clears every slot to address zero, status absent, AS zero at once,
// and forgets the previous route; no clearing pass is needed.
module ipv4_query_asn_matcher
	import iqam_pkg::*;
#(
	parameter int NUM_QUERIES = NUM_QUERIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	iqam_req_if.sink    req,
	iqam_rsp_if.source  rsp
);

	// Row of transactions: tok[0] leaves the entry stage, tok[i+1] leaves cell i.
	tok_t tok [NUM_QUERIES+1];

	logic                rsp_valid_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [ASN_W-1:0]    rsp_asn_q;
	logic                en;
	tok_t                tail;

	// Advance the row whenever the output register is empty or being emptied.
	assign en = !rsp_valid_q || rsp.ready;
	assign req.ready = en;

	// Drop repeated routes and precompute the prefix mask before the row.
	iqam_head u_head (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.req_valid    (req.valid),
		.cmd          (req.cmd),
		.slot         (req.slot),
		.query_addr   (req.query_addr),
		.route_prefix (req.route_prefix),
		.route_len    (req.route_len),
		.route_asn    (req.route_asn),
		.tok          (tok[0])
	);

	// One cell per query slot; every transaction meets the cells in slot order, so
	// each cell sees the commands in the order they were accepted.
	for (genvar i = 0; i < NUM_QUERIES; i++) begin : g_cell
		iqam_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign tail = tok[NUM_QUERIES];

	// Output register: capture read transactions leaving the row, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_slot_q   <= '0;
			rsp_addr_q   <= '0;
			rsp_status_q <= '0;
			rsp_asn_q    <= '0;
		end else if (en) begin
			rsp_valid_q  <= tail.valid && (tail.cmd == CMD_READ);
			rsp_slot_q   <= tail.slot;
			rsp_addr_q   <= tail.data;
			rsp_status_q <= tail.status;
			rsp_asn_q    <= tail.asn;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_slot   = rsp_slot_q;
	assign rsp.out_addr   = rsp_addr_q;
	assign rsp.out_status = rsp_status_q;
	assign rsp.out_asn    = rsp_asn_q;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the IPv4 query address to origin AS matcher.
module testbench;
	import iqam_pkg::*;

	localparam int NUM_Q = NUM_QUERIES_DEF;
	// Command code the block must ignore without a response.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// Cycles without any transaction on either channel before the run is abandoned.
	localparam int QUIET_LIMIT = 5000;
	// Non-ignored transactions per randomised phase.
	localparam int PHASE_ITEMS = 460;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] qaddr;
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  len;
		logic [ASN_W-1:0]  asn;
	} request_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
		status_t           status;
		logic [ASN_W-1:0]  asn;
	} readout_t;

	typedef struct packed {
		request_t rq;
		logic     fixed;
		readout_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	iqam_req_if req();
	iqam_rsp_if rsp();

	ipv4_query_asn_matcher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the slot table and of the last route that was taken in.
	logic [ADDR_W-1:0] slot_addr [NUM_Q];
	status_t           slot_status [NUM_Q];
	logic [ASN_W-1:0]  slot_asn [NUM_Q];
	logic [ADDR_W-1:0] last_prefix;
	logic [LEN_W-1:0]  last_len;
	logic              last_seen;

	// Readouts still owed by the block, oldest first.
	readout_t    due_readouts[$];
	script_row_t script[$];

	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_of_phase [4] = '{0, 45, 0, 38};
	int stall_of_phase [4] = '{0, 0, 45, 38};
	// First octets that most random addresses share, so that routes find slots to touch.
	logic [7:0] first_octets [6] = '{8'h00, 8'h0A, 8'h7F, 8'h80, 8'hC0, 8'hFF};

	// Apply one accepted transaction to the shadow table; return 1 when it owes a readout.
	function automatic bit predict_slots(input request_t rq, output readout_t ro);
		logic [ADDR_W-1:0] mask;
		int eff_len;
		ro = '0;
		case (rq.cmd)
			CMD_LOAD: begin
				slot_addr[rq.slot] = rq.qaddr;
				slot_status[rq.slot] = ST_ABSENT;
				slot_asn[rq.slot] = '0;
			end
			CMD_ROUTE: begin
				// Skip a route that repeats the raw prefix and raw length of the last one taken.
				if (!(last_seen && last_prefix == rq.prefix && last_len == rq.len)) begin
					last_seen = 1'b1;
					last_prefix = rq.prefix;
					last_len = rq.len;
					eff_len = (rq.len > LEN_MAX) ? ADDR_W : int'(rq.len);
					// A shift by the full width leaves no bits: length zero covers everything.
					mask = {ADDR_W{1'b1}} << (ADDR_W - eff_len);
					for (int i = 0; i < NUM_Q; i++) begin
						if (slot_addr[i][31:24] == rq.prefix[31:24]) begin
							if (((slot_addr[i] ^ rq.prefix) & mask) == '0) begin
								slot_status[i] = ST_KNOWN;
								slot_asn[i] = rq.asn;
							end else if (slot_status[i] == ST_ABSENT) begin
								slot_status[i] = ST_UNKNOWN;
							end
						end
					end
				end
			end
			CMD_READ: begin
				ro.slot = rq.slot;
				ro.addr = slot_addr[rq.slot];
				ro.status = slot_status[rq.slot];
				ro.asn = (slot_status[rq.slot] == ST_KNOWN) ? slot_asn[rq.slot] : '0;
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Draw one random transaction, mostly routes aimed at the octets held in the table.
	function automatic request_t draw_request();
		request_t rq;
		int pick;
		rq.slot = SLOT_W'($urandom_range(0, NUM_Q - 1));
		rq.qaddr = $urandom();
		rq.prefix = $urandom();
		rq.len = LEN_W'($urandom_range(0, 63));
		rq.asn = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			rq.cmd = CMD_UNUSED;
		end else if (pick < 22) begin
			rq.cmd = CMD_LOAD;
			if ($urandom_range(0, 9) != 0)
				rq.qaddr = {first_octets[$urandom_range(0, 5)], rq.qaddr[23:0]};
		end else if (pick < 45) begin
			rq.cmd = CMD_READ;
		end else begin
			rq.cmd = CMD_ROUTE;
			if ($urandom_range(0, 4) != 0)
				rq.len = LEN_W'($urandom_range(0, 32));
			if (pick < 52 && last_seen) begin
				// Repeat the last route so the duplicate filter is exercised.
				rq.prefix = last_prefix;
				rq.len = last_len;
			end else if ($urandom_range(0, 9) != 0) begin
				// Keep the octet of a held address and disturb a random number of low bits.
				rq.prefix = slot_addr[$urandom_range(0, NUM_Q - 1)]
					^ (rq.prefix & (32'hFFFF_FFFF >> $urandom_range(8, 32)));
			end
		end
		return rq;
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
		input logic [ADDR_W-1:0] qaddr, input logic [ADDR_W-1:0] prefix,
		input logic [LEN_W-1:0] len, input logic [ASN_W-1:0] asn, input logic fixed,
		input logic [ADDR_W-1:0] want_addr, input status_t want_status,
		input logic [ASN_W-1:0] want_asn);
		script_row_t row;
		row.rq = '{cmd: cmd, slot: slot, qaddr: qaddr, prefix: prefix, len: len, asn: asn};
		row.fixed = fixed;
		row.want = '{slot: slot, addr: want_addr, status: want_status, asn: want_asn};
		script.push_back(row);
	endfunction

	// Present one transaction from the falling edge, idling at random, and hold it until taken.
	task automatic issue(input request_t rq, input logic fixed, input readout_t want);
		readout_t ro;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= rq.cmd;
		req.slot <= rq.slot;
		req.query_addr <= rq.qaddr;
		req.route_prefix <= rq.prefix;
		req.route_len <= rq.len;
		req.route_asn <= rq.asn;
		do @(posedge clk); while (!req.ready);
		if (predict_slots(rq, ro))
			due_readouts.push_back(fixed ? want : ro);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t readout %s: expected %h, got %h", $time, what, want, got);
			errors++;
		end
	endtask

	// Stall the response channel at random; the rate follows the current phase.
	always @(negedge clk)
		rsp.ready <= ($urandom_range(0, 99) >= stall_pct);

	// Compare every response transaction with the oldest readout owed.
	always @(posedge clk) begin
		readout_t want;
		if (rsp.valid && rsp.ready) begin
			if (due_readouts.size() == 0) begin
				$display("%0t readout: expected nothing, got slot %0d addr %h status %0d asn %h",
					$time, rsp.out_slot, rsp.out_addr, rsp.out_status, rsp.out_asn);
				errors++;
			end else begin
				want = due_readouts.pop_front();
				check_field("slot", 32'(want.slot), 32'(rsp.out_slot));
				check_field("addr", want.addr, rsp.out_addr);
				check_field("status", 32'(want.status), 32'(rsp.out_status));
				check_field("asn", want.asn, rsp.out_asn);
			end
		end
	end

	// Abandon the run when neither channel moves a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int sent;
		request_t rq;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.slot = '0;
		req.query_addr = '0;
		req.route_prefix = '0;
		req.route_len = '0;
		req.route_asn = '0;
		// Reset state of the shadow table.
		for (int i = 0; i < NUM_Q; i++) begin
			slot_addr[i] = '0;
			slot_status[i] = ST_ABSENT;
			slot_asn[i] = '0;
		end
		last_prefix = '0;
		last_len = '0;
		last_seen = 1'b0;

		// Directed script: rows with fixed set carry a readout worked out by hand.
		// Both ends of the table straight after reset.
		add_row(CMD_READ, 4'd0, '0, '0, '0, '0, 1'b1, 32'h0000_0000, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd15, '0, '0, '0, '0, 1'b1, 32'h0000_0000, ST_ABSENT, '0);
		add_row(CMD_LOAD, 4'd0, 32'h0A00_0001, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_LOAD, 4'd15, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_LOAD, 4'd1, 32'h0A01_0203, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_LOAD, 4'd2, 32'h0B00_0000, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		// A /8 covers both slots in the same octet and hands them the largest AS number.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd0, '0, '0, '0, '0, 1'b1, 32'h0A00_0001, ST_KNOWN, 32'hFFFF_FFFF);
		// Same prefix and length again: drop it, the AS number must not change.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0A00_0000, 6'd8, 32'h0000_0001, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd1, '0, '0, '0, '0, 1'b1, 32'h0A01_0203, ST_KNOWN, 32'hFFFF_FFFF);
		// Same octet, not covered: absent turns unknown.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0B80_0000, 6'd9, 32'd5, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd2, '0, '0, '0, '0, 1'b1, 32'h0B00_0000, ST_UNKNOWN, '0);
		// Lengths above 32 saturate, yet 40 and 33 are still distinct routes.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0B80_0000, 6'd40, 32'd7, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0B80_0000, 6'd33, 32'd8, 1'b0, '0, ST_ABSENT, '0);
		// Length zero covers every address within the octet.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0B12_3456, 6'd0, 32'd9, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd2, '0, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_ROUTE, 4'd0, '0, 32'hFFFF_FFFF, 6'd32, 32'd0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd15, '0, '0, '0, '0, 1'b1, 32'hFFFF_FFFF, ST_KNOWN, 32'd0);
		// Slots never loaded act as address zero and match a host route to zero.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0000_0000, 6'd63, 32'h1234_5678, 1'b0, '0, ST_ABSENT,
			'0);
		add_row(CMD_READ, 4'd7, '0, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		// A known slot that misses a later route keeps its status and AS number.
		add_row(CMD_ROUTE, 4'd0, '0, 32'h0A00_0001, 6'd32, 32'd3, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_READ, 4'd1, '0, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		// Reloading a slot clears it; the unused command changes nothing.
		add_row(CMD_LOAD, 4'd0, 32'h0A00_0001, '0, '0, '0, 1'b0, '0, ST_ABSENT, '0);
		add_row(CMD_UNUSED, 4'd0, 32'hFFFF_FFFF, 32'h0A00_0001, 6'd32, 32'd11, 1'b0, '0,
			ST_ABSENT, '0);
		add_row(CMD_READ, 4'd0, '0, '0, '0, '0, 1'b1, 32'h0A00_0001, ST_ABSENT, '0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Run the script with both channels flowing freely.
		foreach (script[i])
			issue(script[i].rq, script[i].fixed, script[i].want);

		// Random phases: free flow, idle sender, stalling receiver, then both together.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_of_phase[ph];
			stall_pct = stall_of_phase[ph];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				rq = draw_request();
				issue(rq, 1'b0, '0);
				if (rq.cmd != CMD_UNUSED)
					sent++;
			end
		end

		// Release the request channel, drain the owed readouts, then watch for strays.
		@(negedge clk);
		req.valid <= 1'b0;
		while (due_readouts.size() != 0)
			@(posedge clk);
		repeat (NUM_Q + 8) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
